// ===== rtl/core/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions for the aes encryption core
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned ROW_W = 4;
	localparam int unsigned WIDX_W = 6;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_SIZE = 3'd4;

	localparam logic [1:0] SIZE_128 = 2'd0;
	localparam logic [1:0] SIZE_192 = 2'd1;
	localparam logic [1:0] SIZE_256 = 2'd2;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_RD0,
		ST_ARK0,
		ST_ROUND,
		ST_DONE
	} aes_state_t;

	typedef struct packed {
		logic              load_pt;
		logic              exp_start;
		logic              exp_en;
		logic [WIDX_W-1:0] widx;
		logic [2:0]        wmod;
		logic              ark0;
		logic              round_en;
		logic              last;
		logic              out_load;
		logic [ROW_W-1:0]  raddr;
	} aes_cmd_t;

	typedef struct packed {
		logic [3:0] nk;
		logic [3:0] nr;
	} aes_stat_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte b of the state sits at bits 127-8b downto 120-8b
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] = SBOX[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32*c -: 8];
			a1 = s[119 - 32*c -: 8];
			a2 = s[111 - 32*c -: 8];
			a3 = s[103 - 32*c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		mix_columns = t;
	endfunction

endpackage

// ===== rtl/core/aes_if.sv =====
// ----------------------------------------------------------------------------
// aes channel interfaces
// plaintext, ciphertext and configuration write channels
// ----------------------------------------------------------------------------
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_hi;
	logic [63:0] plain_lo;
	modport source (output valid, output plain_hi, output plain_lo, input ready);
	modport sink (input valid, input plain_hi, input plain_lo, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;
	modport source (output valid, output cipher_hi, output cipher_lo, input ready);
	modport sink (input valid, input cipher_hi, input cipher_lo, output ready);
endinterface

interface aes_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion, rounds and result hand-off
// ----------------------------------------------------------------------------
module aes_ctrl
	import aes_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      cfg_hit,
	input  aes_stat_t stat,
	output aes_cmd_t  cmd
);

	aes_state_t        state_q, state_d;
	logic              keys_ready_q;
	logic [WIDX_W-1:0] wi_q;
	logic [2:0]        wm_q;
	logic [3:0]        rnd_q;
	logic              out_valid_q;
	logic [6:0]        total;
	logic              wi_last;

	assign total   = {1'b0, stat.nr + 4'd1, 2'b00} ;
	assign wi_last = {1'b0, wi_q} == total - 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.widx = wi_q;
		cmd.wmod = wm_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_pt = 1'b1;
					cmd.exp_start = !keys_ready_q;
					state_d = keys_ready_q ? ST_RD0 : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				cmd.exp_en = 1'b1;
				if (wi_last) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: begin
				state_d = ST_ARK0;
			end
			ST_ARK0: begin
				cmd.ark0 = 1'b1;
				cmd.raddr = ROW_W'(1);
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				cmd.last = rnd_q == stat.nr;
				cmd.raddr = cmd.last ? '0 : rnd_q + 4'd1;
				if (cmd.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_ready_q <= 1'b0;
			wi_q <= '0;
			wm_q <= '0;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				keys_ready_q <= 1'b0;
			end else if (cmd.exp_en && wi_last) begin
				keys_ready_q <= 1'b1;
			end
			if (cmd.exp_start) begin
				wi_q <= '0;
				wm_q <= '0;
			end else if (cmd.exp_en) begin
				wi_q <= wi_q + 1'b1;
				wm_q <= ({1'b0, wm_q} == stat.nk - 4'd1) ? 3'd0 : wm_q + 3'd1;
			end
			if (cmd.ark0) begin
				rnd_q <= 4'd1;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_keys_from_expand: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keys_ready_q) |-> $past(state_q) == ST_EXPAND)
		else $error("keys marked ready outside expansion");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q <= stat.nr)
		else $error("round counter past last round");

	a_round_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en && cmd.last |=> state_q == ST_DONE)
		else $error("last round did not finish");

endmodule

// ===== rtl/core/aes_dp.sv =====
// ----------------------------------------------------------------------------
// aes_dp
// key registers, key schedule, round-key memory and round datapath
// ----------------------------------------------------------------------------
module aes_dp
	import aes_pkg::*;
#(
	parameter int unsigned ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [63:0] plain_hi,
	input  logic [63:0] plain_lo,
	input  aes_cmd_t    cmd,
	output aes_stat_t   stat,
	output logic [63:0] cipher_hi,
	output logic [63:0] cipher_lo
);

	localparam int unsigned ROWS = ROUND_KEY_WORDS / 4;
	localparam int unsigned AW = $clog2(ROWS);
	localparam logic [1:0] MAX_SEL = (ROUND_KEY_WORDS >= 60) ? SIZE_256 :
		(ROUND_KEY_WORDS >= 52) ? SIZE_192 : SIZE_128;

	logic [63:0]  key_q [4];
	logic [1:0]   size_q;
	logic [1:0]   sel;
	logic [31:0]  sh_q [8];
	logic [31:0]  rb_q [3];
	logic [7:0]   rcon_q;
	logic [127:0] mem [ROWS];
	logic [127:0] rd_q;
	logic [127:0] st_q;
	logic [127:0] out_q;
	logic [31:0]  kw, t, w;
	logic [63:0]  kr;
	logic [127:0] sb;

	always_comb begin
		sel = (size_q == 2'd3) ? SIZE_256 : size_q;
		if (sel > MAX_SEL) begin
			sel = MAX_SEL;
		end
		stat.nk = 4'd4 + {1'b0, sel, 1'b0};
		stat.nr = stat.nk + 4'd6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
			size_q <= SIZE_128;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				REG_SIZE: size_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// next schedule word
	always_comb begin
		kr = key_q[cmd.widx[2:1]];
		kw = cmd.widx[0] ? kr[31:0] : kr[63:32];
		t = sh_q[0];
		if (cmd.wmod == 3'd0) begin
			t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
		end else if (stat.nk == 4'd8 && cmd.wmod == 3'd4) begin
			t = sub_word(t);
		end
		w = ({2'b00, cmd.widx} < {4'b0, stat.nk}) ? kw : (sh_q[3'(stat.nk - 4'd1)] ^ t);
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			rcon_q <= 8'h01;
		end else if (cmd.exp_en) begin
			for (int j = 7; j > 0; j--) begin
				sh_q[j] <= sh_q[j-1];
			end
			sh_q[0] <= w;
			rb_q[2] <= rb_q[1];
			rb_q[1] <= rb_q[0];
			rb_q[0] <= w;
			if (cmd.wmod == 3'd0 && {2'b00, cmd.widx} >= {4'b0, stat.nk}) begin
				rcon_q <= xtime(rcon_q);
			end
			if (cmd.widx[1:0] == 2'd3) begin
				mem[AW'(cmd.widx[WIDX_W-1:2])] <= {rb_q[2], rb_q[1], rb_q[0], w};
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[cmd.raddr[AW-1:0]];
	end

	assign sb = sub_shift(st_q);

	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			st_q <= {plain_hi, plain_lo};
		end else if (cmd.ark0) begin
			st_q <= st_q ^ rd_q;
		end else if (cmd.round_en) begin
			st_q <= (cmd.last ? sb : mix_columns(sb)) ^ rd_q;
		end
		if (cmd.out_load) begin
			out_q <= st_q;
		end
	end

	assign cipher_hi = out_q[127:64];
	assign cipher_lo = out_q[63:0];

endmodule

// ===== rtl/core/aes_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes_block_encrypt
// aes-128/192/256 block encryption core
// ----------------------------------------------------------------------------
// One plaintext block is taken at a time and one ciphertext block returned.
// A taken block passes through the states RD0, ARK0, one ROUND per round and
// DONE, which waits for the output register to be free; no new block is taken
// before IDLE. The round unit does one round per cycle with one round-key row
// read per round from the registered round-key memory. The first block after
// reset or after a write to a key or size register first expands the key, one
// schedule word per cycle, producing 4*(Nr+1) words (44, 52 or 60 for 128, 192
// or 256-bit keys). The finished block sits in an output register, so a new
// block is taken while the previous result waits.
// ----------------------------------------------------------------------------
module aes_block_encrypt
	import aes_pkg::*;
#(
	parameter int unsigned ROUND_KEY_WORDS = 60
) (
	input  logic clk,
	input  logic arst_n,
	aes_cfg_if.sink   cfg,
	aes_in_if.sink    plain_in,
	aes_out_if.source cipher_out
);

	aes_cmd_t  cmd;
	aes_stat_t stat;
	logic      cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid;

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (plain_in.valid),
		.in_ready  (plain_in.ready),
		.out_valid (cipher_out.valid),
		.out_ready (cipher_out.ready),
		.cfg_hit   (cfg_we && cfg.index <= REG_SIZE),
		.stat      (stat),
		.cmd       (cmd)
	);

	aes_dp #(
		.ROUND_KEY_WORDS(ROUND_KEY_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.plain_hi  (plain_in.plain_hi),
		.plain_lo  (plain_in.plain_lo),
		.cmd       (cmd),
		.stat      (stat),
		.cipher_hi (cipher_out.cipher_hi),
		.cipher_lo (cipher_out.cipher_lo)
	);

endmodule
